@@ rtl/cvrc_pkg.sv @@
// Package with the word types and register map of the coverage run coalescer.
package cvrc_pkg;

	// Input word: one position with its coverage, or a flush marker.
	typedef struct packed {
		logic [30:0] position;
		logic [31:0] coverage;
		logic        flush;
	} item_word_t;

	// Output word: one emitted run.
	typedef struct packed {
		logic [30:0] run_start;
		logic [30:0] run_end;
		logic [31:0] score;
	} run_word_t;

	// Configuration register map, as register indexes (byte address is 4 * index).
	localparam int unsigned CfgAddrW = 5;
	localparam logic [2:0] REG_SCALE_FACTOR = 3'd0;
	localparam logic [2:0] REG_MIN_COVER    = 3'd1;
	localparam logic [2:0] REG_MAX_COVER    = 3'd2;
	localparam logic [2:0] REG_REGION_LOW   = 3'd3;
	localparam logic [2:0] REG_REGION_HIGH  = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [31:0] SCALE_FACTOR_RST = 32'h0001_0000;
	localparam logic [15:0] MIN_COVER_RST    = 16'd0;
	localparam logic [15:0] MAX_COVER_RST    = 16'd0;
	localparam logic [30:0] REGION_LOW_RST   = 31'd0;
	localparam logic [30:0] REGION_HIGH_RST  = 31'h7FFF_FFFF;

	// Scores are counted in hundredths.
	localparam logic [6:0] HUNDRED = 7'd100;

endpackage

@@ rtl/coverage_run_coalescer.sv @@
// Top level of the coverage run coalescer: pipeline, run tracking and register port.
//
// The item channel (item_valid, item_ready, item) takes one word per cycle while the
// pipeline does not hold: a 1-based position with its 16.16 coverage, or a flush
// word that closes the pass. Positions outside (region_low, region_high] are dropped.
// The run channel (run_valid, run_ready, run) gives a run when a word closes it: a
// gap, a change of score, or a flush, if its score lies within the cover limits. A
// word moves through an input register, a multiply stage, a rounding stage and the
// run tracking stage that loads the output register. Throughput is one word per
// cycle, set by the single 32x32 multiplier stage. When run_ready is low and a run
// is waiting, the whole pipeline holds; one more word is caught in a skid register,
// after which item_ready drops. item_ready is driven straight from a register. Reset
// clears the held run, the pipeline valid bits and the configuration registers to
// their default values; the block can take words in the first cycle after reset.
// The APB port is always ready.
module coverage_run_coalescer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  cvrc_pkg::item_word_t                item,
	output logic                                run_valid,
	input  logic                                run_ready,
	output cvrc_pkg::run_word_t                 run,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cvrc_pkg::CfgAddrW-1:0]       paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import cvrc_pkg::*;

	// Configuration registers.
	logic [31:0] scale_factor_q;
	logic [15:0] min_cover_q;
	logic [15:0] max_cover_q;
	logic [30:0] region_low_q;
	logic [30:0] region_high_q;
	logic [2:0]  reg_idx;
	logic        cfg_write;

	// Skid register and pipeline stages.
	logic        skid_valid_q;
	item_word_t  skid_q;
	item_word_t  front_word;
	logic        front_valid;
	logic        advance;

	logic        valid_s1;
	item_word_t  word_s1;
	logic        keep_s1;

	logic        valid_s2;
	logic [30:0] pos_s2;
	logic        flush_s2;
	logic [63:0] prod_s2;

	logic        valid_s3;
	logic [30:0] pos_s3;
	logic        flush_s3;
	logic [31:0] score_s3;

	// Rounding of the product.
	logic [39:0] whole100;
	logic [39:0] frac100;
	logic [39:0] score_sum;
	logic [31:0] score_sat;

	// Held run and output register.
	logic [30:0] held_start_q;
	logic [30:0] held_end_q;
	logic [31:0] held_score_q;
	logic        held_valid_q;
	logic        run_valid_q;
	run_word_t   run_q;

	logic [22:0] min_limit;
	logic [22:0] max_limit;
	logic        offer_ok;
	logic        new_run;
	logic        emit;

	// APB register access.
	assign pready    = 1'b1;
	assign reg_idx   = paddr[CfgAddrW-1:2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_factor_q <= SCALE_FACTOR_RST;
			min_cover_q    <= MIN_COVER_RST;
			max_cover_q    <= MAX_COVER_RST;
			region_low_q   <= REGION_LOW_RST;
			region_high_q  <= REGION_HIGH_RST;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_SCALE_FACTOR: scale_factor_q <= pwdata;
				REG_MIN_COVER:    min_cover_q    <= pwdata[15:0];
				REG_MAX_COVER:    max_cover_q    <= pwdata[15:0];
				REG_REGION_LOW:   region_low_q   <= pwdata[30:0];
				REG_REGION_HIGH:  region_high_q  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SCALE_FACTOR: prdata = scale_factor_q;
			REG_MIN_COVER:    prdata = {16'd0, min_cover_q};
			REG_MAX_COVER:    prdata = {16'd0, max_cover_q};
			REG_REGION_LOW:   prdata = {1'b0, region_low_q};
			REG_REGION_HIGH:  prdata = {1'b0, region_high_q};
			default:          prdata = 32'd0;
		endcase
	end

	// The pipeline moves whenever the output register is free or being emptied.
	assign advance     = !run_valid_q || run_ready;
	assign item_ready  = !skid_valid_q;
	assign front_word  = skid_valid_q ? skid_q : item;
	assign front_valid = skid_valid_q || item_valid;

	// Skid register: catches one word taken while the pipeline holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (advance) begin
			skid_valid_q <= 1'b0;
		end else if (item_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!advance && item_valid && !skid_valid_q) begin
			skid_q <= item;
		end
	end

	// Valid bits of the stages; dropped positions leave the pipe after the input register.
	assign keep_s1 = word_s1.flush ||
		(word_s1.position > region_low_q && word_s1.position <= region_high_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= front_valid;
			valid_s2 <= valid_s1 && keep_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage payloads: input register, the weight product, then the rounded score.
	always_ff @(posedge clk) begin
		if (advance) begin
			word_s1  <= front_word;
			pos_s2   <= word_s1.position;
			flush_s2 <= word_s1.flush;
			prod_s2  <= 64'(word_s1.coverage) * 64'(scale_factor_q);
			pos_s3   <= pos_s2;
			flush_s3 <= flush_s2;
			score_s3 <= score_sat;
		end
	end

	// Score is 100 times the 32.32 product, rounded half up, saturated to 32 bits.
	assign whole100  = 40'(prod_s2[63:32]) * 40'(HUNDRED);
	assign frac100   = 40'(prod_s2[31:0]) * 40'(HUNDRED) + 40'h00_8000_0000;
	assign score_sum = whole100 + {32'd0, frac100[39:32]};
	assign score_sat = (score_sum[39:32] != 8'd0) ? 32'hFFFF_FFFF : score_sum[31:0];

	// Emission limits of the held run.
	assign min_limit = 23'(min_cover_q) * 23'(HUNDRED);
	assign max_limit = 23'(max_cover_q) * 23'(HUNDRED);
	assign offer_ok  = held_valid_q && (held_score_q >= {9'd0, min_limit}) &&
		((max_cover_q == 16'd0) || (held_score_q <= {9'd0, max_limit}));

	// A position opens a new run at a gap, a change of score, or with no run held.
	assign new_run = !held_valid_q || ({1'b0, pos_s3} > ({1'b0, held_end_q} + 32'd1)) ||
		(score_s3 != held_score_q);
	assign emit = valid_s3 && (flush_s3 || new_run) && offer_ok;

	// Held run tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_start_q <= 31'd0;
			held_end_q   <= 31'd0;
			held_score_q <= 32'd0;
			held_valid_q <= 1'b0;
		end else if (advance && valid_s3) begin
			if (flush_s3) begin
				held_start_q <= 31'd0;
				held_end_q   <= 31'd0;
				held_score_q <= 32'd0;
				held_valid_q <= 1'b0;
			end else begin
				if (new_run) begin
					held_start_q <= pos_s3 - 31'd1;
					held_score_q <= score_s3;
					held_valid_q <= 1'b1;
				end
				held_end_q <= pos_s3;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
		end else if (advance) begin
			run_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			run_q.run_start <= held_start_q;
			run_q.run_end   <= held_end_q;
			run_q.score     <= held_score_q;
		end
	end

	assign run_valid = run_valid_q;
	assign run       = run_q;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the coverage run coalescer with a built-in run predictor.
module tb;
	import cvrc_pkg::*;

	// Cycles with no accepted word before the run is declared hung.
	localparam int unsigned IDLE_LIMIT = 4000;
	// Pipeline depth plus skid, with margin, for words that close no run.
	localparam int unsigned SETTLE_CYCLES = 12;
	// Length of the forced receiver hold-off that backs up the pipeline.
	localparam int unsigned LONG_HOLD = 300;
	// A register index with nothing behind it.
	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_word_t item = '0;
	logic run_valid;
	logic run_ready = 1'b0;
	run_word_t run;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CfgAddrW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Shadow copy of the configuration registers.
	logic [31:0] cfg_scale = SCALE_FACTOR_RST;
	logic [15:0] cfg_min = MIN_COVER_RST;
	logic [15:0] cfg_max = MAX_COVER_RST;
	logic [30:0] cfg_low = REGION_LOW_RST;
	logic [30:0] cfg_high = REGION_HIGH_RST;

	// Predicted run currently being extended.
	logic [30:0] held_first = '0;
	logic [30:0] held_last = '0;
	logic [31:0] held_level = '0;
	logic held_open = 1'b0;

	item_word_t words_to_send[$];
	run_word_t runs_due[$];

	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	bit pressure_on = 1'b0;
	bit hold_done = 1'b0;
	int unsigned hold_left = 0;
	int unsigned errors = 0;
	int unsigned idle_cycles = 0;

	coverage_run_coalescer dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.run_valid(run_valid),
		.run_ready(run_ready),
		.run(run),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Free-running clock, 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void flag_mismatch(string msg);
		errors++;
		if (errors <= 10) begin
			$display("tb: mismatch %0d: %s", errors, msg);
		end
	endfunction

	// The held run is expected on the output only if its score is inside the cover limits.
	function automatic void offer_held_run();
		run_word_t r;
		if (held_open && 64'(held_level) >= 64'd100 * 64'(cfg_min) &&
				(cfg_max == 16'd0 || 64'(held_level) <= 64'd100 * 64'(cfg_max))) begin
			r.run_start = held_first;
			r.run_end = held_last;
			r.score = held_level;
			runs_due.insert(runs_due.size(), r);
		end
	endfunction

	// Advance the predicted run state by one accepted word.
	function automatic void predict_runs(item_word_t w);
		logic [63:0] product;
		logic [63:0] rounded;
		logic [31:0] level;
		if (w.flush) begin
			offer_held_run();
			held_first = '0;
			held_last = '0;
			held_level = '0;
			held_open = 1'b0;
		end else if (w.position > cfg_low && w.position <= cfg_high) begin
			// Exact 32.32 product, scaled to hundredths, rounded half up, saturated.
			product = 64'(w.coverage) * 64'(cfg_scale);
			rounded = 64'(product[63:32]) * 64'd100 +
				((64'(product[31:0]) * 64'd100 + 64'h8000_0000) >> 32);
			level = (rounded > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rounded[31:0];
			if (!held_open || 32'(w.position) > 32'(held_last) + 32'd1 ||
					level != held_level) begin
				offer_held_run();
				held_first = w.position - 31'd1;
				held_level = level;
				held_open = 1'b1;
			end
			held_last = w.position;
		end
	endfunction

	function automatic void queue_position(logic [30:0] pos, logic [31:0] cov);
		item_word_t w;
		w.position = pos;
		w.coverage = cov;
		w.flush = 1'b0;
		words_to_send.insert(words_to_send.size(), w);
	endfunction

	// Flush words carry random position and coverage, which must be ignored.
	function automatic void queue_flush();
		item_word_t w;
		w.position = 31'($urandom);
		w.coverage = $urandom;
		w.flush = 1'b1;
		words_to_send.insert(words_to_send.size(), w);
	endfunction

	// One pass: mostly ascending positions inside the region with repeating coverage,
	// mixed with gaps, steps back, stray positions and early flushes.
	task automatic queue_pass(int unsigned count);
		logic [63:0] pos;
		logic [63:0] span;
		logic [31:0] palette [3];
		logic [31:0] cov;
		int unsigned step;
		span = (cfg_high > cfg_low) ? 64'(cfg_high - cfg_low) : 64'd1;
		if ($urandom_range(0, 2) == 0) begin
			pos = 64'(cfg_low) + 64'd1;
		end else begin
			pos = 64'(cfg_low) + 64'd1 + (64'($urandom) % span);
		end
		foreach (palette[j]) begin
			case ($urandom_range(0, 2))
				0: palette[j] = $urandom;
				1: palette[j] = 32'($urandom_range(0, 16)) << 16;
				default: palette[j] = 32'($urandom_range(0, 32'h3_FFFF));
			endcase
		end
		cov = palette[0];
		for (int i = 0; i < count; i++) begin
			step = $urandom_range(0, 39);
			if (step < 2) begin
				queue_position(31'($urandom), $urandom);
			end else if (step == 2) begin
				queue_flush();
			end else begin
				if (step == 3 && pos > 64'd4) begin
					pos = pos - 64'($urandom_range(1, 4));
				end else if (step < 8) begin
					pos = pos + 64'($urandom_range(2, 6));
				end else if (i != 0) begin
					pos = pos + 64'd1;
				end
				if ($urandom_range(0, 3) == 0) begin
					cov = palette[$urandom_range(0, 2)];
				end
				if (pos <= 64'h7FFF_FFFF) begin
					queue_position(pos[30:0], cov);
				end
			end
		end
		queue_flush();
	endtask

	task automatic queue_random_passes();
		int unsigned queued;
		int unsigned k;
		queued = 0;
		while (queued < 65) begin
			k = $urandom_range(1, 30);
			queue_pass(k);
			queued += k + 1;
		end
	endtask

	// APB write: setup cycle, access cycle, then release; the shadow follows the register.
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SCALE_FACTOR: cfg_scale = value;
			REG_MIN_COVER: cfg_min = value[15:0];
			REG_MAX_COVER: cfg_max = value[15:0];
			REG_REGION_LOW: cfg_low = value[30:0];
			REG_REGION_HIGH: cfg_high = value[30:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [31:0] scale, logic [15:0] lo_cover, logic [15:0] hi_cover,
			logic [30:0] low, logic [30:0] high);
		write_reg(REG_SCALE_FACTOR, scale);
		write_reg(REG_MIN_COVER, {16'h0, lo_cover});
		write_reg(REG_MAX_COVER, {16'h0, hi_cover});
		write_reg(REG_REGION_LOW, {1'b0, low});
		write_reg(REG_REGION_HIGH, {1'b0, high});
	endtask

	// Wait until every word is taken and every run has come, then let the pipeline empty.
	task automatic drain();
		while (words_to_send.size() != 0 || item_valid || runs_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Word driver: offers queued words, with random idle cycles between them.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				predict_runs(item);
			end
			if (!item_valid || item_ready) begin
				if (words_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					item <= words_to_send.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Run monitor: checks each accepted run and drives run_ready with stalls.
	always @(posedge clk) begin : run_monitor
		run_word_t want;
		if (!arst_n) begin
			run_ready <= 1'b0;
		end else begin
			if (run_valid && run_ready) begin
				if (runs_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected run: start %0d end %0d score %0d",
						run.run_start, run.run_end, run.score));
				end else begin
					want = runs_due.pop_front();
					if (run.run_start !== want.run_start || run.run_end !== want.run_end ||
							run.score !== want.score) begin
						flag_mismatch($sformatf(
							"expected start %0d end %0d score %0d, got start %0d end %0d score %0d",
							want.run_start, want.run_end, want.score,
							run.run_start, run.run_end, run.score));
					end
				end
			end
			// A single long hold-off lets the pipeline fill and push back on the sender.
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				run_ready <= 1'b0;
			end else if (pressure_on && !hold_done) begin
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
				run_ready <= 1'b0;
			end else begin
				run_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (run_valid && run_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty flush, position zero, extension, score change, gap,
		// steps back, top of the position range and rounding at one half.
		queue_flush();
		queue_position(31'd0, 32'd5);
		queue_position(31'd1, 32'h0001_0000);
		queue_position(31'd2, 32'h0001_0000);
		queue_position(31'd3, 32'h0001_8000);
		queue_position(31'd5, 32'h0001_8000);
		queue_position(31'd4, 32'h0001_8000);
		queue_position(31'd2, 32'h0001_8000);
		queue_position(31'd3, 32'h0000_7FFF);
		queue_position(31'h7FFF_FFFF, 32'hFFFF_FFFF);
		queue_position(31'h7FFF_FFFE, 32'hFFFF_FFFF);
		queue_flush();
		queue_flush();
		queue_position(31'd1, 32'h0000_8000);
		queue_position(31'd2, 32'h0000_2000);
		drain();

		// A run is still held while the weight and minimum change; the minimum is
		// written with junk in its upper bits and an unused index is written too.
		write_reg(REG_SCALE_FACTOR, 32'hFFFF_FFFF);
		write_reg(REG_UNUSED, 32'h1234_5678);
		write_reg(REG_MIN_COVER, 32'hABCD_0001);
		cfg_min = cfg_min;
		queue_position(31'd10, 32'hFFFF_FFFF);
		queue_position(31'd11, 32'hFFFF_FFFF);
		queue_position(31'd12, 32'h0001_0000);
		queue_position(31'd13, 32'h0000_0000);
		queue_flush();
		drain();

		// Empty regions: low equal to high, then low above high.
		write_reg(REG_REGION_LOW, 32'd100);
		write_reg(REG_REGION_HIGH, 32'd100);
		queue_position(31'd100, 32'h0001_0000);
		queue_position(31'd101, 32'h0001_0000);
		queue_flush();
		drain();
		write_reg(REG_REGION_LOW, 32'd200);
		write_reg(REG_REGION_HIGH, 32'd50);
		queue_position(31'd60, 32'h0002_0000);
		queue_position(31'd150, 32'h0002_0000);
		queue_flush();
		drain();

		// Random passes, default weight, no idling.
		configure(SCALE_FACTOR_RST, 16'd0, 16'd0, 31'd0, 31'h7FFF_FFFF);
		queue_random_passes();
		drain();

		// Random weight and limits in a random region, sender mostly idle.
		sender_idle_pct = 87;
		configure(32'($urandom_range(0, 32'h0004_0000)), 16'($urandom_range(0, 3)),
			16'($urandom_range(50, 2000)), 31'($urandom_range(0, 32'h7FFF_0000)), 31'h0);
		write_reg(REG_REGION_HIGH, {1'b0, cfg_low} + 32'($urandom_range(50, 65535)));
		queue_random_passes();
		drain();

		// Largest weight, receiver mostly stalling, one long hold-off.
		sender_idle_pct = 0;
		receiver_stall_pct = 87;
		pressure_on = 1'b1;
		configure(32'hFFFF_FFFF, 16'd0, 16'd0, 31'd0, 31'h7FFF_FFFF);
		queue_random_passes();
		drain();

		// Zero weight at the top of the position range, both sides idling.
		pressure_on = 1'b0;
		sender_idle_pct = 36;
		receiver_stall_pct = 36;
		configure(32'h0, 16'd0, 16'hFFFF, 31'h7FFF_FF00, 31'h7FFF_FFFF);
		queue_random_passes();
		drain();

		// Highest minimum with no upper limit, no idling.
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		configure($urandom | 32'h8000_0000, 16'hFFFF, 16'd0, 31'd0, 31'h7FFF_FFFF);
		queue_random_passes();
		drain();

		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/cvrc_pkg.sv
rtl/coverage_run_coalescer.sv
tb/sv/tb.sv
